/* rtl/sde_pkg.sv */
// shared types, constants and round functions for the sha-256 digest engine
// no dependencies; used by sde_core and sha256_digest_engine
package sde_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        word_last;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FOLD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       start;
        logic       round;
        logic [5:0] round_idx;
        logic       fold;
        logic       reinit;
        logic [2:0] word_sel;
    } t_core_ctl;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [7:0] PAD_ZERO  = 8'h00;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] FILL_LEN  = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST = 3'd7;
    localparam logic [2:0] LEN_LAST  = 3'd7;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] v);
        big_sig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] v);
        big_sig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] v);
        sml_sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] v);
        sml_sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

/* rtl/sde_core.sv */
// sha-256 datapath: block buffer / rolling schedule, working variables, chain values
// depends on sde_pkg; sequenced by sha256_digest_engine
module sde_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sde_pkg::t_core_ctl i_ctl,
    output logic [31:0]       o_word
);
    import sde_pkg::*;

    logic [31:0] r_sched [16];
    logic [31:0] r_vars  [8];
    logic [31:0] r_chain [8];

    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // window holds w[r] .. w[r+15]; append w[r+16] each round
    assign w_new = sml_sig1(r_sched[14]) + r_sched[9] + sml_sig0(r_sched[1]) + r_sched[0];

    assign ch  = (r_vars[4] & r_vars[5]) ^ (~r_vars[4] & r_vars[6]);
    assign maj = (r_vars[0] & r_vars[1]) ^ (r_vars[0] & r_vars[2]) ^ (r_vars[1] & r_vars[2]);
    assign t1  = r_vars[7] + big_sig1(r_vars[4]) + ch + ROUND_K[i_ctl.round_idx] + r_sched[0];
    assign t2  = big_sig0(r_vars[0]) + maj;

    // byte fill shifts the whole 512-bit buffer left by one byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            for (int j = 0; j < 15; j++) begin
                r_sched[j] <= {r_sched[j][23:0], r_sched[j+1][31:24]};
            end
            r_sched[15] <= {r_sched[15][23:0], i_ctl.push_byte};
        end else if (i_ctl.round) begin
            for (int j = 0; j < 15; j++) begin
                r_sched[j] <= r_sched[j+1];
            end
            r_sched[15] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_vars <= r_chain;
        end else if (i_ctl.round) begin
            r_vars[7] <= r_vars[6];
            r_vars[6] <= r_vars[5];
            r_vars[5] <= r_vars[4];
            r_vars[4] <= r_vars[3] + t1;
            r_vars[3] <= r_vars[2];
            r_vars[2] <= r_vars[1];
            r_vars[1] <= r_vars[0];
            r_vars[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.reinit) begin
            r_chain <= INIT_HASH;
        end else if (i_ctl.fold) begin
            for (int j = 0; j < 8; j++) begin
                r_chain[j] <= r_chain[j] + r_vars[j];
            end
        end
    end

    assign o_word = r_chain[i_ctl.word_sel];

endmodule

/* rtl/sha256_digest_engine.sv */
// sha-256 message digest engine, one message byte per input beat
// usage: push bytes on the input channel, mark the final beat with last_byte
// (has_byte may be 0 on that beat to end without a byte, e.g. empty message)
// input beat: byte_value, has_byte, last_byte; output beat: digest_word, word_last
// a byte beat is taken whenever the engine is idle; the 64th byte of a block starts the
// compression: 64 rounds at one round per cycle, then a fold into the chain values, and
// o_in_stall stays high from the 64th byte until the fold is done
// on the last beat the engine appends 0x80, zero fill and the 64-bit bit
// length, one byte per cycle except while a compression runs; padding may run one or two
// compressions, then presents eight digest beats, h0 first, word_last on h7
// the first digest beat comes once the padding pushes and their compressions are done
// input is stalled from the last beat until the eighth digest beat is taken
// a stall on the output holds the current digest beat unchanged
// reset (synchronous, active low) loads the standard initial hash values and
// clears the byte count and bit length; the engine returns to that state by
// itself after each digest
// depends on sde_pkg and sde_core
module sha256_digest_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sde_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sde_pkg::t_out_beat o_out_data
);
    import sde_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_core_ctl ctl;

    logic [5:0]  r_fill;
    logic [5:0]  n_fill;
    logic [63:0] r_bitlen;
    logic [63:0] n_bitlen;
    logic [5:0]  r_round;
    logic [5:0]  n_round;
    logic [2:0]  r_out_idx;
    logic [2:0]  n_out_idx;
    logic [2:0]  r_len_idx;
    logic [2:0]  n_len_idx;
    logic        r_padding;
    logic        n_padding;
    logic        r_mark_done;
    logic        n_mark_done;
    logic        r_len_phase;
    logic        n_len_phase;
    logic        r_pad_done;
    logic        n_pad_done;

    logic        in_acc;
    logic        out_acc;
    logic        in_len;
    logic        msg_done;
    logic [63:0] len_shift;
    logic [7:0]  pad_byte;
    logic [31:0] core_word;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = o_out_valid && !i_out_stall;
    assign msg_done = out_acc && (r_out_idx == WORD_LAST);

    // length bytes go out big-endian once the fill reaches byte 56
    assign in_len    = r_mark_done && (r_len_phase || (r_fill == FILL_LEN));
    assign len_shift = r_bitlen >> {~r_len_idx, 3'b000};

    always_comb begin
        if (!r_mark_done) begin
            pad_byte = PAD_MARK;
        end else if (in_len) begin
            pad_byte = len_shift[7:0];
        end else begin
            pad_byte = PAD_ZERO;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.has_byte && (r_fill == FILL_LAST)) begin
                        n_state = S_ROUND;
                    end else if (i_in_data.last_byte) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_fill == FILL_LAST) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_round == ROUND_LAST) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (r_pad_done) begin
                    n_state = S_OUT;
                end else if (r_padding) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (msg_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        o_out_valid     = (r_state == S_OUT);
        ctl.push        = (in_acc && i_in_data.has_byte) || (r_state == S_PAD);
        ctl.push_byte   = (r_state == S_PAD) ? pad_byte : i_in_data.byte_value;
        ctl.start       = ctl.push && (r_fill == FILL_LAST);
        ctl.round       = (r_state == S_ROUND);
        ctl.round_idx   = r_round;
        ctl.fold        = (r_state == S_FOLD);
        ctl.reinit      = msg_done;
        ctl.word_sel    = r_out_idx;
        o_out_data.digest_word = core_word;
        o_out_data.word_last   = (r_out_idx == WORD_LAST);
    end

    // counters and padding progress
    always_comb begin
        n_fill      = r_fill;
        n_bitlen    = r_bitlen;
        n_round     = (r_state == S_ROUND) ? r_round + 6'd1 : '0;
        n_out_idx   = r_out_idx;
        n_len_idx   = r_len_idx;
        n_padding   = r_padding;
        n_mark_done = r_mark_done;
        n_len_phase = r_len_phase;
        n_pad_done  = r_pad_done;
        if (ctl.push) begin
            n_fill = r_fill + 6'd1;
        end
        if (in_acc && i_in_data.has_byte) begin
            n_bitlen = r_bitlen + 64'd8;
        end
        if (in_acc && i_in_data.last_byte) begin
            n_padding = 1'b1;
        end
        if (r_state == S_PAD) begin
            if (!r_mark_done) begin
                n_mark_done = 1'b1;
            end else if (in_len) begin
                n_len_phase = 1'b1;
                n_len_idx   = r_len_idx + 3'd1;
                if (r_len_idx == LEN_LAST) begin
                    n_pad_done = 1'b1;
                end
            end
        end
        if (out_acc) begin
            n_out_idx = r_out_idx + 3'd1;
        end
        // digest fully delivered: back to the reset state
        if (msg_done) begin
            n_fill      = '0;
            n_bitlen    = '0;
            n_out_idx   = '0;
            n_len_idx   = '0;
            n_padding   = 1'b0;
            n_mark_done = 1'b0;
            n_len_phase = 1'b0;
            n_pad_done  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_bitlen    <= '0;
            r_round     <= '0;
            r_out_idx   <= '0;
            r_len_idx   <= '0;
            r_padding   <= 1'b0;
            r_mark_done <= 1'b0;
            r_len_phase <= 1'b0;
            r_pad_done  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_bitlen    <= n_bitlen;
            r_round     <= n_round;
            r_out_idx   <= n_out_idx;
            r_len_idx   <= n_len_idx;
            r_padding   <= n_padding;
            r_mark_done <= n_mark_done;
            r_len_phase <= n_len_phase;
            r_pad_done  <= n_pad_done;
        end
    end

    sde_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_word  (core_word)
    );

`ifndef SYNTHESIS
    // a compression always runs all 64 rounds back to back
    a_rounds_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) && (r_round != ROUND_LAST) |=> (r_state == S_ROUND))
        else $error("compression left early");

    // a block boundary during fill always starts a compression
    a_block_compress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.push && (r_fill == FILL_LAST) |=> (r_state == S_ROUND) && (r_round == '0))
        else $error("full block not compressed");

    // digest beats only after the length bytes are in
    a_out_after_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pad_done && (r_fill == '0))
        else $error("digest presented before padding finished");

    // last digest beat taken returns the engine to idle
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_out_data.word_last |=> !o_out_valid && !o_in_stall)
        else $error("engine did not return to idle after digest");
`endif

endmodule
